// ===== design/hpil_printer_interface_assert.svh =====
// assertion macros for the hp-il printer interface
`ifndef HPIL_PRINTER_INTERFACE_ASSERT_SVH
`define HPIL_PRINTER_INTERFACE_ASSERT_SVH

`ifndef SYNTHESIS
`define HPIL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HPIL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HPIL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HPIL_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/hpil_pkg.sv =====
package hpil_pkg;

	localparam int unsigned BUF_DEPTH_DEF = 2048;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [10:0] FRAME_EOT   = 11'h540;
	localparam logic [7:0]  READY_MASK  = 8'h39;
	localparam logic [7:0]  READY_VALUE = 8'h10;
	localparam logic [7:0]  AAD_LIMIT   = 8'h9E;

	localparam logic [7:0] ACCESSORY_ID_RST    = 8'd64;
	localparam logic [4:0] DEFAULT_ADDRESS_RST = 5'd4;

	// register index, taken from paddr[2]
	localparam logic REG_ACCESSORY_ID    = 1'b0;
	localparam logic REG_DEFAULT_ADDRESS = 1'b1;

	// role encoding: bit 1 listen addressed, bit 0 talker
	localparam logic [1:0] ROLE_IDLE     = 2'd0;
	localparam logic [1:0] ROLE_TALKER   = 2'd1;
	localparam logic [1:0] ROLE_LISTENER = 2'd2;
	localparam logic [1:0] ROLE_ACTIVE   = 2'd3;

	typedef enum logic [3:0] {
		OP_TICK,
		OP_DATA,
		OP_SDC,
		OP_DCL,
		OP_UNL,
		OP_LAD,
		OP_TAD,
		OP_IFC,
		OP_AAU,
		OP_NRD,
		OP_SST,
		OP_SDI,
		OP_SAI,
		OP_AAD,
		OP_PASS
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [10:0] frame;
		logic [7:0]  status;
	} entry_t;

	// device id string, zero after the last character
	function automatic logic [7:0] dev_ident(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h4C;
			3'd1: c = 8'h50;
			3'd2: c = 8'h52;
			3'd3: c = 8'h54;
			3'd4: c = 8'h45;
			3'd5: c = 8'h52;
			3'd6: c = 8'h31;
			3'd7: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== design/hpil_front.sv =====
module hpil_front (
	input  logic             op,
	input  logic [10:0]      frame_in,
	input  logic [7:0]       printer_status,
	output hpil_pkg::entry_t entry
);
	import hpil_pkg::*;

	logic [7:0] n;
	logic [4:0] a;
	logic [2:0] grp;

	assign n   = frame_in[7:0];
	assign a   = n[4:0];
	assign grp = n[7:5];

	always_comb begin
		entry.frame  = frame_in;
		entry.status = printer_status;
		priority if (op) begin
			entry.op = OP_TICK;
		end else if (!frame_in[10]) begin
			entry.op = OP_DATA;
		end else if (frame_in[9:8] == 2'b00) begin
			// command class
			priority if (n == 8'd4) entry.op = OP_SDC;
			else if (n == 8'd20) entry.op = OP_DCL;
			else if (grp == 3'd1 && a == 5'd31) entry.op = OP_UNL;
			else if (grp == 3'd1) entry.op = OP_LAD;
			else if (grp == 3'd2) entry.op = OP_TAD;
			else if (grp == 3'd4 && a == 5'd16) entry.op = OP_IFC;
			else if (grp == 3'd4 && a == 5'd26) entry.op = OP_AAU;
			else entry.op = OP_PASS;
		end else if (frame_in[9:8] == 2'b01) begin
			// ready class
			priority if (n == 8'd66) entry.op = OP_NRD;
			else if (n == 8'd97) entry.op = OP_SST;
			else if (n == 8'd98) entry.op = OP_SDI;
			else if (n == 8'd99) entry.op = OP_SAI;
			else if (n[7] && n < AAD_LIMIT) entry.op = OP_AAD;
			else entry.op = OP_PASS;
		end else begin
			entry.op = OP_PASS;
		end
	end

endmodule

// ===== design/hpil_queue.sv =====
module hpil_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  hpil_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop,
	output hpil_pkg::entry_t pop_entry
);
	import hpil_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               full;
	logic               push;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign push_stall = full;
	assign push       = push_valid && !full;
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/hpil_back.sv =====
`include "hpil_printer_interface_assert.svh"

module hpil_back #(
	parameter int unsigned BUF_DEPTH = hpil_pkg::BUF_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  hpil_pkg::entry_t q_entry,
	output logic             q_pop,
	input  logic [7:0]       accessory_id,
	input  logic [4:0]       default_address,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [10:0]      frame_out,
	output logic             print_valid,
	output logic [7:0]       print_char,
	output logic             char_dropped,
	output logic [10:0]      buffer_level
);
	import hpil_pkg::*;

	localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUF_DEPTH - 1);

	logic [7:0]       char_mem [BUF_DEPTH];
	logic [7:0]       rdata_q;

	logic [1:0]       role_q, role_n;
	logic [7:0]       addr_q, addr_n;
	logic [2:0]       idp_q, idp_n;
	logic [IDX_W-1:0] wr_idx_q, wr_idx_n;
	logic [IDX_W-1:0] rd_idx_q, rd_idx_n;
	logic [IDX_W-1:0] count_q, count_n;

	logic             exec;
	logic             wr_en, rd_en;
	logic [10:0]      frame_n;
	logic             drop_n;
	logic [7:0]       n;
	logic [4:0]       a;
	logic [4:0]       mine;
	logic [7:0]       c;

	logic             out_valid_q;
	logic [10:0]      out_frame_q;
	logic             out_pvalid_q;
	logic             out_drop_q;
	logic [10:0]      out_level_q;

	assign exec  = q_valid && (!out_valid_q || !out_stall);
	assign q_pop = exec;
	assign n     = q_entry.frame[7:0];
	assign a     = n[4:0];
	assign mine  = addr_q[4:0];

	always_comb begin
		role_n   = role_q;
		addr_n   = addr_q;
		idp_n    = idp_q;
		wr_idx_n = wr_idx_q;
		rd_idx_n = rd_idx_q;
		count_n  = count_q;
		frame_n  = q_entry.frame;
		drop_n   = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		c        = dev_ident(idp_q);
		unique case (q_entry.op)
			OP_TICK: begin
				if (count_q != '0 && (q_entry.status & READY_MASK) == READY_VALUE) begin
					rd_en    = 1'b1;
					rd_idx_n = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
					count_n  = count_q - 1'b1;
				end
			end
			OP_DATA: begin
				if (role_q == ROLE_ACTIVE) begin
					if (idp_q != 3'd0) begin
						frame_n = {3'b000, c};
						idp_n   = (c == 8'd0) ? 3'd0 : idp_q + 1'b1;
					end
					// id string done or none in progress: send eot and fall back to addressed talker
					if (idp_n == 3'd0) begin
						frame_n = FRAME_EOT;
						role_n  = ROLE_TALKER;
					end
				end else if (role_q == ROLE_LISTENER) begin
					if (count_q != IDX_LAST) begin
						wr_en    = 1'b1;
						wr_idx_n = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
						count_n  = count_q + 1'b1;
					end else begin
						drop_n = 1'b1;
					end
				end
			end
			OP_SDC: begin
				if (role_q[1]) begin
					wr_idx_n = '0;
					rd_idx_n = '0;
					count_n  = '0;
				end
			end
			OP_DCL: begin
				wr_idx_n = '0;
				rd_idx_n = '0;
				count_n  = '0;
			end
			OP_UNL: begin
				if (!role_q[0]) role_n = ROLE_IDLE;
			end
			OP_LAD: begin
				if (a == mine) role_n = ROLE_LISTENER;
			end
			OP_TAD: begin
				if (a == mine) role_n = ROLE_TALKER;
				else if (role_q[0]) role_n = ROLE_IDLE;
			end
			OP_IFC: role_n = ROLE_IDLE;
			OP_AAU: addr_n = {3'b000, default_address};
			OP_NRD: begin
				if (role_q[0]) idp_n = 3'd0;
			end
			OP_SST: begin
				if (role_q[0]) begin
					frame_n = {3'b000, q_entry.status};
					role_n  = ROLE_ACTIVE;
				end
			end
			OP_SDI: begin
				if (role_q[0]) begin
					frame_n = {3'b000, dev_ident(3'd0)};
					idp_n   = 3'd1;
					role_n  = ROLE_ACTIVE;
				end
			end
			OP_SAI: begin
				if (role_q[0]) begin
					frame_n = {3'b000, accessory_id};
					role_n  = ROLE_ACTIVE;
				end
			end
			OP_AAD: begin
				// auto address taken once until aau; bit 7 marks it
				if (!addr_q[7]) begin
					addr_n  = n;
					frame_n = q_entry.frame + 11'd1;
				end
			end
			OP_PASS: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec && wr_en) char_mem[wr_idx_q] <= n;
		if (exec && rd_en) rdata_q <= char_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q   <= ROLE_IDLE;
			addr_q   <= '0;
			idp_q    <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else if (exec) begin
			role_q   <= role_n;
			addr_q   <= addr_n;
			idp_q    <= idp_n;
			wr_idx_q <= wr_idx_n;
			rd_idx_q <= rd_idx_n;
			count_q  <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_frame_q  <= frame_n;
			out_pvalid_q <= rd_en;
			out_drop_q   <= drop_n;
			out_level_q  <= 11'(count_n);
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_out    = out_frame_q;
	assign print_valid  = out_pvalid_q;
	assign print_char   = out_pvalid_q ? rdata_q : 8'd0;
	assign char_dropped = out_drop_q;
	assign buffer_level = out_level_q;

	`HPIL_ASSERT_IMP(a_level_max, clk, arst_n, 1'b1, count_q <= IDX_LAST)
	`HPIL_ASSERT_IMP(a_drop_when_full, clk, arst_n, exec && drop_n, count_q == IDX_LAST)
	`HPIL_ASSERT_NXT(a_drain_one, clk, arst_n, exec && rd_en, count_q == $past(count_q) - 1'b1)
	`HPIL_ASSERT_IMP(a_active_by_ready, clk, arst_n, exec && role_n == ROLE_ACTIVE && role_q != ROLE_ACTIVE, q_entry.op == OP_SST || q_entry.op == OP_SDI || q_entry.op == OP_SAI)

endmodule

// ===== design/hpil_printer_interface.sv =====
// a result is registered in the output stage when its transaction leaves the queue, and held while stalled
// throughput: one transaction per cycle while out_stall is low, frames and drain ticks alike
// a two-entry queue sits between decode and execute; the character buffer is a
// single-port-per-side memory written by listener data and read by drain ticks
// reset: role, loop address, id pointer and buffer indices go to zero, registers to
// 64 and 4; buffer contents are not cleared and the block is ready at once
module hpil_printer_interface #(
	parameter int unsigned BUF_DEPTH = hpil_pkg::BUF_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [10:0] frame_in,
	input  logic [7:0]  printer_status,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] frame_out,
	output logic        print_valid,
	output logic [7:0]  print_char,
	output logic        char_dropped,
	output logic [10:0] buffer_level
);
	import hpil_pkg::*;

	logic [7:0] accessory_id_q;
	logic [4:0] default_address_q;
	logic       cfg_wr;
	entry_t     front_entry;
	entry_t     q_entry;
	logic       q_valid;
	logic       q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accessory_id_q    <= ACCESSORY_ID_RST;
			default_address_q <= DEFAULT_ADDRESS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ACCESSORY_ID:    accessory_id_q    <= pwdata[7:0];
				REG_DEFAULT_ADDRESS: default_address_q <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACCESSORY_ID:    prdata = {24'd0, accessory_id_q};
			REG_DEFAULT_ADDRESS: prdata = {27'd0, default_address_q};
		endcase
	end

	hpil_front u_front (
		.op             (op),
		.frame_in       (frame_in),
		.printer_status (printer_status),
		.entry          (front_entry)
	);

	hpil_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (in_stall),
		.push_entry (front_entry),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_entry  (q_entry)
	);

	hpil_back #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_entry         (q_entry),
		.q_pop           (q_pop),
		.accessory_id    (accessory_id_q),
		.default_address (default_address_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_out       (frame_out),
		.print_valid     (print_valid),
		.print_char      (print_char),
		.char_dropped    (char_dropped),
		.buffer_level    (buffer_level)
	);

endmodule

// ===== sim/tb_hpil_printer_interface.sv =====
module tb_hpil_printer_interface;
	import hpil_pkg::*;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [2:0] CLASS_CMD  = 3'd4;
	localparam logic [2:0] CLASS_RDY  = 3'd5;
	localparam logic [2:0] CLASS_XTRA = 3'd6;

	// command groups, payload bits 7..5
	localparam logic [2:0] GRP_MISC   = 3'd0;
	localparam logic [2:0] GRP_LISTEN = 3'd1;
	localparam logic [2:0] GRP_TALK   = 3'd2;
	localparam logic [2:0] GRP_UNIV   = 3'd4;

	localparam logic [4:0] ADDR_ALL = 5'd31;
	localparam logic [4:0] UNIV_IFC = 5'd16;
	localparam logic [4:0] UNIV_AAU = 5'd26;

	localparam logic [7:0] CMD_SDC = 8'd4;
	localparam logic [7:0] CMD_DCL = 8'd20;
	localparam logic [7:0] RDY_NRD = 8'd66;
	localparam logic [7:0] RDY_SST = 8'd97;
	localparam logic [7:0] RDY_SDI = 8'd98;
	localparam logic [7:0] RDY_SAI = 8'd99;
	localparam logic [7:0] RDY_AAD = 8'h80;

	localparam logic [10:0] FULL_LEVEL = 11'd2047;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [10:0] frame;
		logic        pvalid;
		logic [7:0]  pchar;
		logic        dropped;
		logic [10:0] level;
	} reply_t;

	class printer_shadow;
		logic [7:0]  accessory_id;
		logic [4:0]  default_addr;
		logic [1:0]  role;
		logic [7:0]  loop_addr;
		logic [2:0]  id_ptr;
		logic [7:0]  chars [2048];
		logic [10:0] wr_idx;
		logic [10:0] rd_idx;
		logic [7:0]  ident_chars [8];
		reply_t      replies_due [$];
		int          faults;

		function new();
			// "LPRTER1" then a zero
			ident_chars = '{8'h4C, 8'h50, 8'h52, 8'h54, 8'h45, 8'h52, 8'h31, 8'h00};
			accessory_id = ACCESSORY_ID_RST;
			default_addr = DEFAULT_ADDRESS_RST;
			role = ROLE_IDLE;
			loop_addr = 8'd0;
			id_ptr = 3'd0;
			wr_idx = 11'd0;
			rd_idx = 11'd0;
			faults = 0;
		endfunction

		function void set_reg(logic sel, logic [31:0] v);
			if (sel == REG_ACCESSORY_ID)
				accessory_id = v[7:0];
			else
				default_addr = v[4:0];
		endfunction

		function logic [10:0] level();
			return wr_idx - rd_idx;
		endfunction

		function void take_item(logic o, logic [10:0] f, logic [7:0] s);
			reply_t r;
			logic [7:0] n;
			logic [4:0] a;
			logic [7:0] c;
			n = f[7:0];
			a = n[4:0];
			r.frame = f;
			r.pvalid = 1'b0;
			r.pchar = 8'd0;
			r.dropped = 1'b0;
			if (o == OP_DRAIN) begin
				if (level() != 0 && (s & READY_MASK) == READY_VALUE) begin
					r.pvalid = 1'b1;
					r.pchar = chars[rd_idx];
					rd_idx = rd_idx + 11'd1;
				end
			end else if (!f[10]) begin
				if (role == ROLE_ACTIVE) begin
					if (id_ptr != 0) begin
						c = ident_chars[id_ptr];
						r.frame = {3'b000, c};
						id_ptr = (c == 8'd0) ? 3'd0 : id_ptr + 3'd1;
					end
					if (id_ptr == 0) begin
						r.frame = FRAME_EOT;
						role = ROLE_TALKER;
					end
				end else if (role == ROLE_LISTENER) begin
					if (level() != FULL_LEVEL) begin
						chars[wr_idx] = n;
						wr_idx = wr_idx + 11'd1;
					end else begin
						r.dropped = 1'b1;
					end
				end
			end else if (f[10:8] == CLASS_CMD) begin
				case (n[7:5])
					GRP_MISC: begin
						if (n == CMD_SDC) begin
							if (role[1]) begin
								wr_idx = 11'd0;
								rd_idx = 11'd0;
							end
						end else if (n == CMD_DCL) begin
							wr_idx = 11'd0;
							rd_idx = 11'd0;
						end
					end
					GRP_LISTEN: begin
						if (a == ADDR_ALL) begin
							if (!role[0])
								role = ROLE_IDLE;
						end else if (a == loop_addr[4:0]) begin
							role = ROLE_LISTENER;
						end
					end
					GRP_TALK: begin
						if (a == loop_addr[4:0])
							role = ROLE_TALKER;
						else if (role[0])
							role = ROLE_IDLE;
					end
					GRP_UNIV: begin
						if (a == UNIV_IFC)
							role = ROLE_IDLE;
						else if (a == UNIV_AAU)
							loop_addr = {3'b000, default_addr};
					end
					default: ;
				endcase
			end else if (f[10:8] == CLASS_RDY) begin
				if (!n[7]) begin
					if (role[0]) begin
						case (n)
							RDY_NRD: id_ptr = 3'd0;
							RDY_SST: begin
								r.frame = {3'b000, s};
								role = ROLE_ACTIVE;
							end
							RDY_SDI: begin
								r.frame = {3'b000, ident_chars[0]};
								id_ptr = 3'd1;
								role = ROLE_ACTIVE;
							end
							RDY_SAI: begin
								r.frame = {3'b000, accessory_id};
								role = ROLE_ACTIVE;
							end
							default: ;
						endcase
					end
				end else if (n < AAD_LIMIT) begin
					// auto address is taken only once until unconfigured
					if (!loop_addr[7]) begin
						loop_addr = n;
						r.frame = f + 11'd1;
					end
				end
			end
			r.level = level();
			replies_due.push_back(r);
		endfunction

		task report(string msg);
			if (faults < 40)
				$display("mismatch: %s", msg);
			faults++;
		endtask

		task match_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("unexpected transaction, frame_out %h", got.frame));
				return;
			end
			want = replies_due.pop_front();
			if (got.frame !== want.frame)
				report($sformatf("frame_out %h, want %h", got.frame, want.frame));
			if (got.pvalid !== want.pvalid)
				report($sformatf("print_valid %b, want %b", got.pvalid, want.pvalid));
			if (got.pchar !== want.pchar)
				report($sformatf("print_char %h, want %h", got.pchar, want.pchar));
			if (got.dropped !== want.dropped)
				report($sformatf("char_dropped %b, want %b", got.dropped, want.dropped));
			if (got.level !== want.level)
				report($sformatf("buffer_level %0d, want %0d", got.level, want.level));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [10:0] frame_in = 11'd0;
	logic [7:0]  printer_status = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] frame_out;
	logic        print_valid;
	logic [7:0]  print_char;
	logic        char_dropped;
	logic [10:0] buffer_level;

	printer_shadow shadow = new();
	bit calm = 1'b0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	int stall_left = 0;
	int sent_items = 0;
	int quiet_cycles = 0;

	hpil_printer_interface dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.frame_in(frame_in),
		.printer_status(printer_status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_out(frame_out),
		.print_valid(print_valid),
		.print_char(print_char),
		.char_dropped(char_dropped),
		.buffer_level(buffer_level)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// receiver stalls in bursts, with quiet stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			out_quiet <= ~out_quiet;
		if (calm || out_quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(negedge clk) begin : watch_results
		reply_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {frame_out, print_valid, print_char, char_dropped, buffer_level};
			shadow.match_reply(got);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet_cycles = 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] pick_status();
		logic [7:0] s;
		s = 8'($urandom);
		if ($urandom_range(0, 3) != 0)
			s = (s & ~READY_MASK) | READY_VALUE;
		return s;
	endfunction

	function automatic logic [10:0] cmd_frame(logic [2:0] grp, logic [4:0] a);
		return {CLASS_CMD, grp, a};
	endfunction

	// called at a rising edge; returns at the edge where the transaction is taken, or after a random idle gap
	task send_item(input logic o, input logic [10:0] f, input logic [7:0] s);
		in_valid <= 1'b1;
		op <= o;
		frame_in <= f;
		printer_status <= s;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		shadow.take_item(o, f, s);
		sent_items++;
		@(posedge clk);
		if (!calm && !in_quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task put_frame(input logic [10:0] f);
		send_item(OP_FRAME, f, 8'($urandom));
	endtask

	task put_tick();
		send_item(OP_DRAIN, 11'($urandom), pick_status());
	endtask

	task write_reg(input logic sel, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		shadow.set_reg(sel, v);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task drain_pending();
		in_valid <= 1'b0;
		while (shadow.replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task retune(input logic [7:0] acc, input logic [4:0] addr);
		drain_pending();
		write_reg(REG_ACCESSORY_ID, {24'd0, acc});
		@(posedge clk);
		write_reg(REG_DEFAULT_ADDRESS, {27'd0, addr});
	endtask

	task opening_items();
		send_item(OP_DRAIN, 11'h7FF, READY_VALUE);
		put_frame(11'h3FF);
		put_frame(cmd_frame(GRP_LISTEN, 5'd0));
		put_frame(11'h0AA);
		put_frame(11'h355);
		send_item(OP_DRAIN, 11'h000, 8'hEF);
		send_item(OP_DRAIN, 11'h2C3, 8'hD6);
		put_frame({CLASS_CMD, CMD_SDC});
		put_frame(11'h0FF);
		put_frame({CLASS_CMD, CMD_DCL});
		put_frame(cmd_frame(GRP_LISTEN, ADDR_ALL));
		put_frame(cmd_frame(GRP_TALK, 5'd0));
		send_item(OP_FRAME, {CLASS_RDY, RDY_SST}, 8'hA5);
		put_frame(11'h000);
		put_frame({CLASS_RDY, RDY_SAI});
		put_frame({CLASS_RDY, RDY_NRD});
		put_frame({CLASS_RDY, RDY_SDI});
		// rest of the id string, then eot
		repeat (7) put_frame({1'b0, 10'($urandom)});
		put_frame({CLASS_RDY, RDY_AAD});
		put_frame({CLASS_RDY, 8'h9D});
		put_frame(cmd_frame(GRP_UNIV, UNIV_AAU));
		put_frame(cmd_frame(GRP_UNIV, UNIV_IFC));
		put_frame({CLASS_XTRA, 8'hAB});
		put_frame(11'h7FF);
		put_frame(11'h5FF);
		put_frame(11'h4E0);
	endtask

	task listen_session();
		logic [4:0] tgt;
		int pick;
		tgt = shadow.loop_addr[4:0];
		if ($urandom_range(0, 4) == 0)
			tgt = 5'($urandom_range(0, 30));
		put_frame(cmd_frame(GRP_LISTEN, tgt));
		repeat ($urandom_range(1, 12)) begin
			pick = $urandom_range(0, 19);
			if (pick < 13)
				put_frame({1'b0, 10'($urandom)});
			else if (pick < 18)
				put_tick();
			else if (pick == 18)
				put_frame({CLASS_CMD, CMD_SDC});
			else
				put_frame({CLASS_CMD, CMD_DCL});
		end
		if ($urandom_range(0, 1) == 0)
			put_frame(cmd_frame(GRP_LISTEN, ADDR_ALL));
	endtask

	task talk_session();
		logic [4:0] tgt;
		logic [7:0] n;
		tgt = shadow.loop_addr[4:0];
		if ($urandom_range(0, 4) == 0)
			tgt = 5'($urandom_range(0, 31));
		put_frame(cmd_frame(GRP_TALK, tgt));
		case ($urandom_range(0, 4))
			0: n = RDY_SST;
			1: n = RDY_SDI;
			2: n = RDY_SAI;
			3: n = RDY_NRD;
			default: n = 8'($urandom_range(0, 127));
		endcase
		put_frame({CLASS_RDY, n});
		repeat ($urandom_range(1, 10)) put_frame({1'b0, 10'($urandom)});
		if ($urandom_range(0, 1) == 0)
			put_frame(cmd_frame(GRP_TALK, shadow.loop_addr[4:0] + 5'd1));
	endtask

	task address_session();
		if ($urandom_range(0, 3) != 0)
			put_frame(cmd_frame(GRP_UNIV, UNIV_AAU));
		else
			put_frame(cmd_frame(GRP_UNIV, UNIV_IFC));
		repeat ($urandom_range(1, 2)) put_frame({CLASS_RDY, 8'($urandom_range(8'h80, 8'hA5))});
		repeat ($urandom_range(0, 3)) put_frame({1'b0, 10'($urandom)});
	endtask

	task noise_burst();
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 2) == 0)
				put_frame({CLASS_CMD, 8'($urandom)});
			else
				send_item(1'($urandom), 11'($urandom), 8'($urandom));
		end
	endtask

	task run_traffic(input int count);
		int target;
		target = sent_items + count;
		while (sent_items < target) begin
			in_quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2: listen_session();
				3, 4: talk_session();
				5: address_session();
				6, 7: repeat ($urandom_range(1, 8)) put_tick();
				default: noise_burst();
			endcase
		end
	endtask

	// fill the buffer past full, drain part of it, overfill it again, then clear it with dcl
	task overflow_run();
		int room;
		put_frame(cmd_frame(GRP_LISTEN, shadow.loop_addr[4:0]));
		room = FULL_LEVEL - shadow.level();
		repeat (room + 4) put_frame({1'b0, 10'($urandom)});
		repeat (20) send_item(OP_DRAIN, 11'($urandom), READY_VALUE);
		repeat (25) put_frame({1'b0, 10'($urandom)});
		repeat (10) put_tick();
		put_frame({CLASS_CMD, CMD_DCL});
		put_frame(cmd_frame(GRP_LISTEN, ADDR_ALL));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		retune(8'hFF, 5'd30);
		opening_items();
		retune(8'h00, 5'd0);
		run_traffic(450);
		retune(8'($urandom), 5'($urandom_range(0, 30)));
		overflow_run();
		retune(8'($urandom), 5'($urandom_range(0, 30)));
		run_traffic(450);
		retune(ACCESSORY_ID_RST, DEFAULT_ADDRESS_RST);
		run_traffic(400);
		calm = 1'b1;
		in_quiet = 1'b1;
		run_traffic(150);
		drain_pending();
		if (shadow.faults == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/hpil_pkg.sv
design/hpil_front.sv
design/hpil_queue.sv
design/hpil_back.sv
design/hpil_printer_interface.sv
sim/tb_hpil_printer_interface.sv
